// ----- design/rrts_pkg.sv -----
// ----------------------------------------------------------------------------
// Round-robin thread scheduler package
// Shared widths, codes, queue entry and cell control types.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int ID_W            = 4;
  localparam int START_W         = 23;
  localparam int TIME_W          = 32;
  localparam int QUANTUM_W       = 16;
  localparam int ACT_W           = 3;
  localparam int QLEN_W          = 5;
  localparam int PROD_W          = 33;
  localparam int MS_PER_S        = 1000;
  localparam int QUANTUM_RESET   = 200;
  localparam int MAX_THREADS_DEF = 16;

  localparam logic [ACT_W-1:0] ACT_ENQUEUE = 3'd0;
  localparam logic [ACT_W-1:0] ACT_YIELD   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_END     = 3'd2;
  localparam logic [ACT_W-1:0] ACT_RUN     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_MARK    = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CHARGE,
    S_SCAN,
    S_REPORT
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_APPEND,
    CELL_ROTATE,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [START_W-1:0] start;
  } entry_t;

  typedef struct packed {
    cell_op_t           op;
    logic               upd;
    logic [ID_W-1:0]    upd_id;
    logic [START_W-1:0] upd_start;
    entry_t             app;
  } cell_ctrl_t;

endpackage

// ----- design/rrts_cell.sv -----
// ----------------------------------------------------------------------------
// Queue cell
// Holds one queued thread id with its start time and passes it along the row.
// ----------------------------------------------------------------------------
module rrts_cell #(
  parameter int POS   = 0,
  parameter int CNT_W = 5
) (
  input  logic                clk,
  input  rrts_pkg::cell_ctrl_t ctrl,
  input  logic [CNT_W-1:0]    count,
  input  rrts_pkg::entry_t    nbr,
  input  rrts_pkg::entry_t    head,
  output rrts_pkg::entry_t    entry
);
  import rrts_pkg::*;

  entry_t entry_next;
  logic   at_tail;
  logic   at_last;

  assign at_tail = (count == CNT_W'(POS));
  assign at_last = (count == CNT_W'(POS + 1));

  always_comb begin
    entry_next = entry;
    case (ctrl.op)
      CELL_HOLD, CELL_APPEND: begin
        if (ctrl.upd && (entry.id == ctrl.upd_id)) begin
          entry_next.start = ctrl.upd_start;
        end
        if ((ctrl.op == CELL_APPEND) && at_tail) begin
          entry_next = ctrl.app;
        end
      end
      CELL_ROTATE: begin
        entry_next = at_last ? head : nbr;
      end
      CELL_SHIFT: begin
        entry_next = nbr;
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ----- design/round_robin_thread_scheduler.sv -----
// ----------------------------------------------------------------------------
// Round-robin thread scheduler
// Wait queue of thread ids with ready marks, start times and a time quantum.
// ----------------------------------------------------------------------------
// One transaction is taken at a time and gives exactly one result. Enqueue,
// set-ready, an unknown action and a yield with no current thread go from
// EXEC straight to the result state REPORT, and a yield that does not walk
// the queue passes through CHARGE first. End and run walk the wait queue:
// the queue is a ring of cells that rotates by one entry per cycle while the
// head cell is checked, one step for each entry in the queue. An expired
// yield first appends the current thread in CHARGE and then walks the longer
// queue, one step for each entry after the append. The
// output register lets the next transaction be accepted while a result is
// still waiting; a result that cannot be loaded stalls the block until the
// waiting one is taken.
module round_robin_thread_scheduler #(
  parameter int MAX_THREADS = rrts_pkg::MAX_THREADS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [rrts_pkg::QUANTUM_W-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rrts_pkg::ACT_W-1:0]    action,
  input  logic [rrts_pkg::ID_W-1:0]     thread_id,
  input  logic [rrts_pkg::START_W-1:0]  start_time_s,
  input  logic                          ready_mark,
  input  logic [rrts_pkg::TIME_W-1:0]   now_ms,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rrts_pkg::ID_W-1:0]     running_id,
  output logic                          running_valid,
  output logic                          switched,
  output logic                          queue_full,
  output logic [rrts_pkg::QLEN_W-1:0]   queue_length
);
  import rrts_pkg::*;

  localparam int CNT_W = $clog2(MAX_THREADS + 1);
  localparam int IDX_W = $clog2(MAX_THREADS);

  state_t state, state_next;

  logic [QUANTUM_W-1:0] quantum;
  logic [ACT_W-1:0]     act_q;
  logic [ID_W-1:0]      tid_q;
  logic [START_W-1:0]   start_q;
  logic                 mark_q;
  logic [TIME_W-1:0]    now_q;

  logic [MAX_THREADS-1:0] thread_ready;
  logic [CNT_W-1:0]       wait_count;
  logic [CNT_W-1:0]       remain;
  logic [TIME_W-1:0]      slice_start;
  logic [TIME_W-1:0]      slice_used;
  logic [TIME_W-1:0]      elapsed;
  logic [ID_W-1:0]        current_thread;
  logic                   current_valid;
  logic [START_W-1:0]     cur_start;
  logic                   sw_flag;
  logic                   full_flag;

  entry_t     cells [MAX_THREADS];
  entry_t     nbr_w [MAX_THREADS];
  cell_ctrl_t cell_ctrl;

  logic              in_acc;
  logic              out_free;
  logic              tid_ok;
  logic              q_full;
  logic              head_elig;
  logic [PROD_W-1:0] head_prod;
  logic [TIME_W:0]   used_sum;
  logic [TIME_W-1:0] used_val;
  logic              expired;
  logic              take;
  logic              do_enq;
  logic              do_requeue;
  logic              load_out;
  logic [QLEN_W-1:0] qlen_sat;

  for (genvar i = 0; i < MAX_THREADS; i++) begin : g_cell
    if (i == MAX_THREADS - 1) begin : g_last
      assign nbr_w[i] = cells[0];
    end else begin : g_mid
      assign nbr_w[i] = cells[i+1];
    end
    rrts_cell #(
      .POS  (i),
      .CNT_W(CNT_W)
    ) u_cell (
      .clk  (clk),
      .ctrl (cell_ctrl),
      .count(wait_count),
      .nbr  (nbr_w[i]),
      .head (cells[0]),
      .entry(cells[i])
    );
  end

  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign tid_ok    = (int'(tid_q) < MAX_THREADS);
  assign q_full    = (wait_count == CNT_W'(MAX_THREADS));
  assign head_prod = PROD_W'(cells[0].start) * PROD_W'(MS_PER_S);
  assign head_elig = thread_ready[IDX_W'(cells[0].id)] && ({1'b0, now_q} >= head_prod);
  assign used_sum  = {1'b0, slice_used} + {1'b0, elapsed};
  assign used_val  = used_sum[TIME_W] ? '1 : used_sum[TIME_W-1:0];
  assign expired   = (used_val >= TIME_W'(quantum));
  assign qlen_sat  = (int'(wait_count) > 31) ? QLEN_W'(31) : QLEN_W'(wait_count);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (act_q) inside
          ACT_YIELD:        state_next = current_valid ? S_CHARGE : S_REPORT;
          ACT_END, ACT_RUN: state_next = S_SCAN;
          default:          state_next = S_REPORT;
        endcase
      end
      S_CHARGE: begin
        state_next = (expired && !q_full) ? S_SCAN : S_REPORT;
      end
      S_SCAN: begin
        if (remain == '0) begin
          state_next = S_REPORT;
        end
      end
      S_REPORT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    do_enq     = (state == S_EXEC) && (act_q == ACT_ENQUEUE) && tid_ok && !q_full;
    do_requeue = (state == S_CHARGE) && expired && !q_full;
    take       = (state == S_SCAN) && (remain != '0) && !sw_flag && head_elig;
    load_out   = (state == S_REPORT) && out_free;

    cell_ctrl           = '0;
    cell_ctrl.op        = CELL_HOLD;
    cell_ctrl.upd_id    = tid_q;
    cell_ctrl.upd_start = start_q;
    if (do_enq) begin
      cell_ctrl.op        = CELL_APPEND;
      cell_ctrl.upd       = 1'b1;
      cell_ctrl.app.id    = tid_q;
      cell_ctrl.app.start = start_q;
    end else if (do_requeue) begin
      cell_ctrl.op        = CELL_APPEND;
      cell_ctrl.app.id    = current_thread;
      cell_ctrl.app.start = cur_start;
    end else if ((state == S_SCAN) && (remain != '0)) begin
      cell_ctrl.op = take ? CELL_SHIFT : CELL_ROTATE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= QUANTUM_W'(QUANTUM_RESET);
    end else if (cfg_we) begin
      quantum <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_q   <= action;
      tid_q   <= thread_id;
      start_q <= start_time_s;
      mark_q  <= ready_mark;
      now_q   <= now_ms;
    end
    if (state == S_EXEC) begin
      elapsed <= (now_q >= slice_start) ? (now_q - slice_start) : '0;
    end
    if (do_enq && (current_thread == tid_q)) begin
      cur_start <= start_q;
    end else if (take) begin
      cur_start <= cells[0].start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thread_ready   <= '0;
      wait_count     <= '0;
      remain         <= '0;
      slice_start    <= '0;
      slice_used     <= '0;
      current_thread <= '0;
      current_valid  <= 1'b0;
      sw_flag        <= 1'b0;
      full_flag      <= 1'b0;
    end else begin
      if (in_acc) begin
        sw_flag   <= 1'b0;
        full_flag <= 1'b0;
      end
      if (state == S_EXEC) begin
        remain <= wait_count;
        if ((act_q == ACT_ENQUEUE) && tid_ok && q_full) begin
          full_flag <= 1'b1;
        end
        if (do_enq) begin
          wait_count <= wait_count + 1'b1;
        end
        if ((act_q == ACT_MARK) && tid_ok) begin
          thread_ready[IDX_W'(tid_q)] <= mark_q;
        end
      end
      if (state == S_CHARGE) begin
        slice_used <= used_val;
        remain     <= wait_count + 1'b1;
        if (do_requeue) begin
          wait_count <= wait_count + 1'b1;
        end else begin
          slice_start <= now_q;
          if (expired) begin
            full_flag <= 1'b1;
          end
        end
      end
      if (state == S_SCAN) begin
        if (remain == '0) begin
          if (!sw_flag && (act_q == ACT_END)) begin
            current_valid <= 1'b0;
          end
        end else begin
          remain <= remain - 1'b1;
        end
        if (take) begin
          wait_count     <= wait_count - 1'b1;
          current_thread <= cells[0].id;
          current_valid  <= 1'b1;
          slice_start    <= now_q;
          slice_used     <= '0;
          sw_flag        <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      running_id    <= current_valid ? current_thread : '0;
      running_valid <= current_valid;
      switched      <= sw_flag;
      queue_full    <= full_flag;
      queue_length  <= qlen_sat;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    wait_count <= CNT_W'(MAX_THREADS))
    else $error("wait queue count exceeds its depth");

  a_take_sets_current: assert property (@(posedge clk) disable iff (rst)
    take |=> (sw_flag && current_valid && (slice_used == '0)))
    else $error("selected thread did not become current");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state == S_EXEC))
    else $error("accepted transaction was not executed");

  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN) && (remain == '0)) |=> (state == S_REPORT))
    else $error("queue walk did not finish");

  a_report_load: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (out_valid && (state == S_IDLE)))
    else $error("result was not presented");
`endif

endmodule
